### rtl/core/lavm_pkg.sv
// Shared types, codes and helper functions for the look-at view matrix block.
`timescale 1ns / 1ps

package lavm_pkg;

    // Row codes of the view matrix
    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;

    // One request: eye, target and up, each signed Q16.16
    typedef struct packed {
        logic [31:0] eye_x;
        logic [31:0] eye_y;
        logic [31:0] eye_z;
        logic [31:0] look_x;
        logic [31:0] look_y;
        logic [31:0] look_z;
        logic [31:0] up_x;
        logic [31:0] up_y;
        logic [31:0] up_z;
    } item_t;

    // Status from the normalize unit
    typedef struct packed {
        logic done;
        logic ok;
    } norm_stat_t;

    // Back-end sequencer states
    typedef enum logic [7:0] {
        B_IDLE     = 8'b0000_0001,
        B_NORM_Z   = 8'b0000_0010,
        B_CROSS_UP = 8'b0000_0100,
        B_NORM_X   = 8'b0000_1000,
        B_CROSS_ZX = 8'b0001_0000,
        B_NORM_Y   = 8'b0010_0000,
        B_TRANS    = 8'b0100_0000,
        B_EMIT     = 8'b1000_0000
    } back_state_t;

    // Normalize unit states
    typedef enum logic [5:0] {
        N_IDLE   = 6'b00_0001,
        N_SCALE  = 6'b00_0010,
        N_SQUARE = 6'b00_0100,
        N_ROOT   = 6'b00_1000,
        N_DLOAD  = 6'b01_0000,
        N_DIVIDE = 6'b10_0000
    } norm_state_t;

    // Cross product a x b, product j: c0 = a1b2 - a2b1, c1 = a2b0 - a0b2, c2 = a0b1 - a1b0
    function automatic logic [1:0] cross_a_idx(input logic [3:0] j);
        logic [1:0] r;
        case (j)
            4'd0:    r = 2'd1;
            4'd1:    r = 2'd2;
            4'd2:    r = 2'd2;
            4'd3:    r = 2'd0;
            4'd4:    r = 2'd0;
            4'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b_idx(input logic [3:0] j);
        logic [1:0] r;
        case (j)
            4'd0:    r = 2'd2;
            4'd1:    r = 2'd1;
            4'd2:    r = 2'd0;
            4'd3:    r = 2'd2;
            4'd4:    r = 2'd1;
            4'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Translation products run row by row, three components each
    function automatic logic [1:0] trans_row(input logic [3:0] j);
        logic [1:0] r;
        case (j)
            4'd0, 4'd1, 4'd2: r = ROW_X;
            4'd3, 4'd4, 4'd5: r = ROW_Y;
            default:          r = ROW_Z;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] trans_comp(input logic [3:0] j);
        logic [1:0] r;
        case (j)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // -(dot) rounded half up to Q16.16, saturated to 32 bits
    function automatic logic [31:0] round_sat(input logic signed [63:0] dot);
        logic signed [65:0] r;
        logic signed [35:0] sh;
        logic [31:0]        res;
        r  = 66'sd0 - 66'(dot) + (66'sd1 <<< 29);
        sh = $signed(r[65:30]);
        if (sh > 36'sd2147483647)
            res = 32'h7FFF_FFFF;
        else if (sh < -36'sd2147483648)
            res = 32'h8000_0000;
        else
            res = sh[31:0];
        return res;
    endfunction

endpackage

### rtl/core/lavm_front.sv
// Front end: accepts requests into a two-entry queue ahead of the back end.
`timescale 1ns / 1ps

module lavm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lavm_pkg::item_t     item,
    output logic                busy,
    output logic                head_valid,
    output lavm_pkg::item_t     head,
    input  logic                pop
);

    lavm_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            do_pop;

    assign busy       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign push       = start && !busy;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

endmodule

### rtl/core/lavm_norm.sv
// Normalize unit: block scaling, sum of squares, bit-serial root and divide.
`timescale 1ns / 1ps

module lavm_norm
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [63:0]      vin  [3],
    output logic signed [31:0]      vout [3],
    output lavm_pkg::norm_stat_t    stat
);

    lavm_pkg::norm_state_t state_reg, state_next;
    logic [63:0]        mag_reg  [3];
    logic [63:0]        mag_next [3];
    logic               neg_reg  [3];
    logic               neg_next [3];
    logic signed [31:0] vout_reg  [3];
    logic signed [31:0] vout_next [3];
    logic [4:0]         cnt_reg, cnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic [59:0]        sq_reg, sq_next;
    logic [61:0]        sum_reg, sum_next;
    logic [30:0]        root_reg, root_next;
    logic [32:0]        rem_reg, rem_next;
    logic [30:0]        drem_reg, drem_next;
    logic [31:0]        dnum_reg, dnum_next;
    logic [31:0]        q_reg, q_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;

    logic               hi_any;
    logic               lo_all;
    logic [34:0]        rt_remx;
    logic [34:0]        rt_trial;
    logic [60:0]        num;
    logic [29:0]        sq_op;
    logic [31:0]        dv_remx;
    logic               dv_ge;
    logic [31:0]        dv_q;

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        vout_next  = vout_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        sq_next    = sq_reg;
        sum_next   = sum_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        drem_next  = drem_reg;
        dnum_next  = dnum_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;

        hi_any   = (mag_reg[0][63:30] != '0) || (mag_reg[1][63:30] != '0)
                || (mag_reg[2][63:30] != '0);
        lo_all   = (mag_reg[0][63:29] == '0) && (mag_reg[1][63:29] == '0)
                && (mag_reg[2][63:29] == '0);
        rt_remx  = {rem_reg, sum_reg[61:60]};
        rt_trial = {2'b00, root_reg, 2'b01};
        num      = {1'b0, mag_reg[comp_reg][29:0], 30'd0} + 61'(root_reg[30:1]);
        sq_op    = mag_reg[cnt_reg[1:0]][29:0];
        dv_remx  = {drem_reg, dnum_reg[31]};
        dv_ge    = (dv_remx >= {1'b0, root_reg});
        dv_q     = {q_reg[30:0], dv_ge};

        case (state_reg)
            lavm_pkg::N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = vin[i][63];
                        mag_next[i] = vin[i][63] ? 64'(-vin[i]) : 64'(vin[i]);
                    end
                    if (vin[0] == '0 && vin[1] == '0 && vin[2] == '0)
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else
                        state_next = lavm_pkg::N_SCALE;
                end
            end

            // One bit of block scaling per cycle until the peak is in [2^29, 2^30)
            lavm_pkg::N_SCALE:
            begin
                if (hi_any)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (lo_all)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    cnt_next   = 5'd0;
                    sum_next   = '0;
                    state_next = lavm_pkg::N_SQUARE;
                end
            end

            // One square per cycle, registered and then added to the running sum
            lavm_pkg::N_SQUARE:
            begin
                if (cnt_reg < 5'd3)
                    sq_next = {30'd0, sq_op} * {30'd0, sq_op};
                if (cnt_reg != 5'd0)
                    sum_next = sum_reg + 62'(sq_reg);
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = 5'd0;
                    root_next  = '0;
                    rem_next   = '0;
                    state_next = lavm_pkg::N_ROOT;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end

            // Digit-by-digit square root, one result bit per cycle
            lavm_pkg::N_ROOT:
            begin
                if (rt_remx >= rt_trial)
                begin
                    rem_next  = 33'(rt_remx - rt_trial);
                    root_next = {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next  = rt_remx[32:0];
                    root_next = {root_reg[29:0], 1'b0};
                end
                sum_next = sum_reg << 2;
                if (cnt_reg == 5'd30)
                begin
                    comp_next  = 2'd0;
                    state_next = lavm_pkg::N_DLOAD;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end

            // Rounded numerator; its top bits are already below the divisor
            lavm_pkg::N_DLOAD:
            begin
                drem_next  = {2'b00, num[60:32]};
                dnum_next  = num[31:0];
                q_next     = '0;
                cnt_next   = 5'd0;
                state_next = lavm_pkg::N_DIVIDE;
            end

            // Restoring divide, one quotient bit per cycle
            lavm_pkg::N_DIVIDE:
            begin
                drem_next = dv_ge ? 31'(dv_remx - {1'b0, root_reg}) : dv_remx[30:0];
                q_next    = dv_q;
                dnum_next = dnum_reg << 1;
                if (cnt_reg == 5'd31)
                begin
                    vout_next[comp_reg] = neg_reg[comp_reg] ? -$signed(dv_q) : $signed(dv_q);
                    if (comp_reg == 2'd2)
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                        state_next = lavm_pkg::N_IDLE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = lavm_pkg::N_DLOAD;
                    end
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end

            default:
                state_next = lavm_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lavm_pkg::N_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        vout_reg <= vout_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        sq_reg   <= sq_next;
        sum_reg  <= sum_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        drem_reg <= drem_next;
        dnum_reg <= dnum_next;
        q_reg    <= q_next;
    end

    assign vout      = vout_reg;
    assign stat.done = done_reg;
    assign stat.ok   = ok_reg;

endmodule

### rtl/core/lavm_back.sv
// Back end: frame sequencer with a shared multiplier and the normalize unit.
`timescale 1ns / 1ps

module lavm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lavm_pkg::item_t     head,
    output logic                pop,
    output logic                result_valid,
    output logic [1:0]          row_index,
    output logic signed [31:0]  axis_x,
    output logic signed [31:0]  axis_y,
    output logic signed [31:0]  axis_z,
    output logic signed [31:0]  translation,
    output logic                degenerate,
    output logic                last_row
);

    lavm_pkg::back_state_t state_reg, state_next;
    lavm_pkg::norm_stat_t  nstat;

    logic signed [31:0] eye_reg [3];
    logic signed [31:0] eye_next [3];
    logic signed [31:0] up_reg [3];
    logic signed [31:0] up_next [3];
    logic signed [31:0] x_reg [3];
    logic signed [31:0] x_next [3];
    logic signed [31:0] y_reg [3];
    logic signed [31:0] y_next [3];
    logic signed [31:0] z_reg [3];
    logic signed [31:0] z_next [3];
    logic signed [63:0] vec_reg [3];
    logic signed [63:0] vec_next [3];
    logic [31:0]        trans_reg [3];
    logic [31:0]        trans_next [3];
    logic signed [31:0] nout [3];
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] tmp_reg, tmp_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         ecnt_reg, ecnt_next;
    logic               degen_reg, degen_next;
    logic               nstart_reg, nstart_next;

    logic               rv_reg, rv_next;
    logic [1:0]         ri_reg, ri_next;
    logic signed [31:0] ax_reg, ax_next;
    logic signed [31:0] ay_reg, ay_next;
    logic signed [31:0] az_reg, az_next;
    logic [31:0]        tr_reg, tr_next;
    logic               dg_reg, dg_next;
    logic               lr_reg, lr_next;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic [3:0]         j;
    logic [1:0]         ai;
    logic [1:0]         bi;
    logic [1:0]         tr_row;
    logic [1:0]         tr_c;
    logic [1:0]         ir;
    logic [1:0]         ic;
    logic signed [63:0] acc_sum;

    lavm_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nstart_reg),
        .vin   (vec_reg),
        .vout  (nout),
        .stat  (nstat)
    );

    // Multiplier operand select
    always_comb
    begin
        ai    = lavm_pkg::cross_a_idx(cnt_reg);
        bi    = lavm_pkg::cross_b_idx(cnt_reg);
        ir    = lavm_pkg::trans_row(cnt_reg);
        ic    = lavm_pkg::trans_comp(cnt_reg);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            lavm_pkg::B_CROSS_UP:
            begin
                mul_a = up_reg[ai];
                mul_b = z_reg[bi];
            end
            lavm_pkg::B_CROSS_ZX:
            begin
                mul_a = z_reg[ai];
                mul_b = x_reg[bi];
            end
            lavm_pkg::B_TRANS:
            begin
                case (ir)
                    lavm_pkg::ROW_X: mul_a = x_reg[ic];
                    lavm_pkg::ROW_Y: mul_a = y_reg[ic];
                    default:         mul_a = z_reg[ic];
                endcase
                mul_b = eye_reg[ic];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        eye_next    = eye_reg;
        up_next     = up_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        vec_next    = vec_reg;
        trans_next  = trans_reg;
        prod_next   = mul_a * mul_b;
        tmp_next    = tmp_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        ecnt_next   = ecnt_reg;
        degen_next  = degen_reg;
        nstart_next = 1'b0;
        pop         = 1'b0;
        rv_next     = 1'b0;
        ri_next     = ri_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        tr_next     = tr_reg;
        dg_next     = dg_reg;
        lr_next     = lr_reg;
        j           = cnt_reg - 4'd1;
        tr_row      = lavm_pkg::trans_row(j);
        tr_c        = lavm_pkg::trans_comp(j);
        acc_sum     = acc_reg + prod_reg;

        case (state_reg)
            lavm_pkg::B_IDLE:
            begin
                if (head_valid)
                begin
                    pop         = 1'b1;
                    eye_next[0] = $signed(head.eye_x);
                    eye_next[1] = $signed(head.eye_y);
                    eye_next[2] = $signed(head.eye_z);
                    up_next[0]  = $signed(head.up_x);
                    up_next[1]  = $signed(head.up_y);
                    up_next[2]  = $signed(head.up_z);
                    vec_next[0] = 64'($signed(head.eye_x)) - 64'($signed(head.look_x));
                    vec_next[1] = 64'($signed(head.eye_y)) - 64'($signed(head.look_y));
                    vec_next[2] = 64'($signed(head.eye_z)) - 64'($signed(head.look_z));
                    degen_next  = 1'b0;
                    nstart_next = 1'b1;
                    state_next  = lavm_pkg::B_NORM_Z;
                end
            end

            lavm_pkg::B_NORM_Z, lavm_pkg::B_NORM_X, lavm_pkg::B_NORM_Y:
            begin
                if (nstat.done)
                begin
                    cnt_next = 4'd0;
                    acc_next = '0;
                    if (!nstat.ok)
                    begin
                        degen_next = 1'b1;
                        ecnt_next  = 2'd0;
                        state_next = lavm_pkg::B_EMIT;
                    end
                    else if (state_reg == lavm_pkg::B_NORM_Z)
                    begin
                        z_next     = nout;
                        state_next = lavm_pkg::B_CROSS_UP;
                    end
                    else if (state_reg == lavm_pkg::B_NORM_X)
                    begin
                        x_next     = nout;
                        state_next = lavm_pkg::B_CROSS_ZX;
                    end
                    else
                    begin
                        y_next     = nout;
                        state_next = lavm_pkg::B_TRANS;
                    end
                end
            end

            // Six products, one per cycle; pairs subtract into the vector
            lavm_pkg::B_CROSS_UP, lavm_pkg::B_CROSS_ZX:
            begin
                if (cnt_reg != 4'd0)
                begin
                    if (!j[0])
                        tmp_next = prod_reg;
                    else
                        vec_next[j[2:1]] = tmp_reg - prod_reg;
                end
                if (cnt_reg == 4'd6)
                begin
                    nstart_next = 1'b1;
                    state_next  = (state_reg == lavm_pkg::B_CROSS_UP)
                                ? lavm_pkg::B_NORM_X : lavm_pkg::B_NORM_Y;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end

            // Nine products, three per row, then round and saturate
            lavm_pkg::B_TRANS:
            begin
                if (cnt_reg != 4'd0)
                begin
                    if (tr_c == 2'd2)
                    begin
                        trans_next[tr_row] = lavm_pkg::round_sat(acc_sum);
                        acc_next           = '0;
                    end
                    else
                        acc_next = acc_sum;
                end
                if (cnt_reg == 4'd9)
                begin
                    ecnt_next  = 2'd0;
                    state_next = lavm_pkg::B_EMIT;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end

            // One row per cycle into the output register
            lavm_pkg::B_EMIT:
            begin
                rv_next = 1'b1;
                ri_next = ecnt_reg;
                dg_next = degen_reg;
                lr_next = (ecnt_reg == lavm_pkg::ROW_Z);
                case (ecnt_reg)
                    lavm_pkg::ROW_X:
                    begin
                        ax_next = x_reg[0];
                        ay_next = x_reg[1];
                        az_next = x_reg[2];
                    end
                    lavm_pkg::ROW_Y:
                    begin
                        ax_next = y_reg[0];
                        ay_next = y_reg[1];
                        az_next = y_reg[2];
                    end
                    default:
                    begin
                        ax_next = z_reg[0];
                        ay_next = z_reg[1];
                        az_next = z_reg[2];
                    end
                endcase
                tr_next = trans_reg[ecnt_reg];
                if (degen_reg)
                begin
                    ax_next = '0;
                    ay_next = '0;
                    az_next = '0;
                    tr_next = '0;
                end
                if (ecnt_reg == lavm_pkg::ROW_Z)
                    state_next = lavm_pkg::B_IDLE;
                else
                    ecnt_next = ecnt_reg + 2'd1;
            end

            default:
                state_next = lavm_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lavm_pkg::B_IDLE;
            nstart_reg <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nstart_reg <= nstart_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg   <= eye_next;
        up_reg    <= up_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        vec_reg   <= vec_next;
        trans_reg <= trans_next;
        prod_reg  <= prod_next;
        tmp_reg   <= tmp_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        ecnt_reg  <= ecnt_next;
        degen_reg <= degen_next;
        ri_reg    <= ri_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        tr_reg    <= tr_next;
        dg_reg    <= dg_next;
        lr_reg    <= lr_next;
    end

    assign result_valid = rv_reg;
    assign row_index    = ri_reg;
    assign axis_x       = ax_reg;
    assign axis_y       = ay_reg;
    assign axis_z       = az_reg;
    assign translation  = tr_reg;
    assign degenerate   = dg_reg;
    assign last_row     = lr_reg;

    // Checks
    a_last_is_z: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && lr_reg |-> ri_reg == lavm_pkg::ROW_Z)
        else $error("last row strobe on a row other than z");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && dg_reg |-> ax_reg == '0 && ay_reg == '0 && az_reg == '0 && tr_reg == '0)
        else $error("degenerate row carries nonzero data");

    a_rows_contig: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && ri_reg != lavm_pkg::ROW_Z |=> rv_reg && ri_reg == $past(ri_reg) + 2'd1)
        else $error("rows of one request not back to back");

    a_norm_start: assert property (@(posedge clk) disable iff (!rst_n)
        nstart_reg |-> state_reg == lavm_pkg::B_NORM_Z || state_reg == lavm_pkg::B_NORM_X
                       || state_reg == lavm_pkg::B_NORM_Y)
        else $error("normalize started outside a normalize phase");

endmodule

### rtl/core/look_at_view_matrix_top.sv
// Top level of the look-at view matrix block.
`timescale 1ns / 1ps

// Look-at view matrix.
// Request channel: drive eye_*, look_*, up_* (signed Q16.16) with start high;
// the request is taken on a rising edge where start is high and busy is low.
// A two-entry queue holds requests while the back end works, so a new request
// is taken while an earlier one is still being computed; busy rises when the
// queue is full.
// Result channel: each request yields three rows (x, y, z axis) on
// consecutive cycles, each marked by result_valid for one cycle; last_row
// marks the z row. The receiver cannot stall the block.
// Work: each request runs three normalizations on one iterative unit
// (block scaling, sum of squares, bit-serial root, then one divide per
// component), plus cross products and translation on the shared multiplier;
// the back end starts the next request only after emitting the z row.
// A zero-length vector cuts the work short and gives degenerate zero rows.
// Reset (rst_n low) empties the queue and returns the sequencer to idle.
module look_at_view_matrix_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  eye_x,
    input  logic signed [31:0]  eye_y,
    input  logic signed [31:0]  eye_z,
    input  logic signed [31:0]  look_x,
    input  logic signed [31:0]  look_y,
    input  logic signed [31:0]  look_z,
    input  logic signed [31:0]  up_x,
    input  logic signed [31:0]  up_y,
    input  logic signed [31:0]  up_z,
    output logic                result_valid,
    output logic [1:0]          row_index,
    output logic signed [31:0]  axis_x,
    output logic signed [31:0]  axis_y,
    output logic signed [31:0]  axis_z,
    output logic signed [31:0]  translation,
    output logic                degenerate,
    output logic                last_row
);

    lavm_pkg::item_t item;
    lavm_pkg::item_t head;
    logic            head_valid;
    logic            pop;

    always_comb
    begin
        item.eye_x  = eye_x;
        item.eye_y  = eye_y;
        item.eye_z  = eye_z;
        item.look_x = look_x;
        item.look_y = look_y;
        item.look_z = look_z;
        item.up_x   = up_x;
        item.up_y   = up_y;
        item.up_z   = up_z;
    end

    lavm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    lavm_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .row_index    (row_index),
        .axis_x       (axis_x),
        .axis_y       (axis_y),
        .axis_z       (axis_z),
        .translation  (translation),
        .degenerate   (degenerate),
        .last_row     (last_row)
    );

endmodule
